// ===== src/assert_macros.svh =====
// Assertion macros shared by the lookup block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: check failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error("%m: check failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== src/til_pkg.sv =====
// ----------------------------------------------------------------------------
// til_pkg: shared types and constants
// Widths, table depth and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none
package til_pkg;
	localparam int MaxPoints = 64;
	localparam int IdxBits   = 6;
	localparam int CntBits   = 7;
	localparam int VBits     = 32;
	localparam int PBits     = 2 * VBits;

	localparam logic [1:0] ImodeInterp = 2'd0;
	localparam logic [1:0] ImodeFwd    = 2'd1;
	localparam logic [1:0] ImodeBwd    = 2'd2;

	typedef struct packed {
		logic                  wr;      // write one point
		logic                  rd;      // read entry rd_idx
		logic [IdxBits-1:0]    rd_idx;
		logic                  cap_cur; // latch current read as hit
		logic                  cap_prev;// keep current read as previous
		logic                  mul;     // form product
		logic                  div_go;  // start divide
		logic                  div_step;
		logic                  fin;     // form result
	} cmd_t;

	typedef struct packed {
		logic ge;      // read key at or above query
		logic eq;      // read key equal to query
		logic div_done;
	} sts_t;
endpackage
`default_nettype wire

// ===== src/til_datapath.sv =====
// ----------------------------------------------------------------------------
// til_datapath: table storage and arithmetic
// Two column memories, a multiplier and a shift-subtract divider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module til_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire til_pkg::cmd_t                       cmd,
	output til_pkg::sts_t                            sts,
	input  wire logic [til_pkg::IdxBits-1:0]         wr_idx,
	input  wire logic signed [til_pkg::VBits-1:0]    wx,
	input  wire logic signed [til_pkg::VBits-1:0]    wy,
	input  wire logic signed [til_pkg::VBits-1:0]    q_in,
	input  wire logic                                inv_in,
	input  wire logic                                sel_prev,
	output logic signed [til_pkg::VBits-1:0]         res
);
	localparam int V = til_pkg::VBits;
	localparam int P = til_pkg::PBits;

	logic [V-1:0] xmem [til_pkg::MaxPoints];
	logic [V-1:0] ymem [til_pkg::MaxPoints];
	logic signed [V-1:0] rk_q, rv_q, ck_q, cv_q, pk_q, pv_q, q_q;
	logic inv_q, neg_q;
	logic [P-1:0] prod_q;
	logic [V:0]   dx_q;
	logic [V:0]   rem_q;
	logic [V-1:0] quo_q;
	logic [P-1:0] num_q;
	logic [6:0]   cnt_q;
	logic [V-1:0] rx, ry;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			xmem[wr_idx] <= wx;
			ymem[wr_idx] <= wy;
		end
		if (cmd.rd) begin
			rx <= xmem[cmd.rd_idx];
			ry <= ymem[cmd.rd_idx];
		end
	end

	always_comb begin
		rk_q = inv_q ? ry : rx;
		rv_q = inv_q ? rx : ry;
	end

	assign sts.ge = rk_q >= q_q;
	assign sts.eq = rk_q == q_q;
	assign sts.div_done = (cnt_q == 7'd0);

	logic [V:0] dv_abs, dq;
	logic [V:0] trial;
	always_comb begin
		dv_abs = (cv_q >= pv_q) ? ({cv_q[V-1], cv_q} - {pv_q[V-1], pv_q})
		                        : ({pv_q[V-1], pv_q} - {cv_q[V-1], cv_q});
		dq = {q_q[V-1], q_q} - {pk_q[V-1], pk_q};
		trial = {rem_q[V-1:0], num_q[P-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			inv_q <= 1'b0;
		end else begin
			if (cmd.div_go) cnt_q <= 7'(P);
			else if (cmd.div_step && cnt_q != 7'd0) cnt_q <= cnt_q - 7'd1;
			inv_q <= inv_in;
		end
	end

	always_ff @(posedge clk) begin
		q_q <= q_in;
		if (cmd.cap_prev) begin
			pk_q <= rk_q;
			pv_q <= rv_q;
		end
		if (cmd.cap_cur) begin
			ck_q <= rk_q;
			cv_q <= rv_q;
		end
		if (cmd.mul) begin
			// Both factors fit in 32 unsigned bits; dq is below dx.
			prod_q <= P'(dv_abs[V-1:0]) * P'(dq[V-1:0]);
			neg_q  <= cv_q < pv_q;
			dx_q   <= {ck_q[V-1], ck_q} - {pk_q[V-1], pk_q};
		end
		if (cmd.div_go) begin
			num_q <= prod_q;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step && cnt_q != 7'd0) begin
			num_q <= {num_q[P-2:0], 1'b0};
			if ({rem_q[V], trial} >= {1'b0, dx_q}) begin
				rem_q <= (V+1)'(({rem_q[V], trial}) - {1'b0, dx_q});
				quo_q <= {quo_q[V-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[V-2:0], 1'b0};
			end
		end
		if (cmd.fin) begin
			if (sel_prev) res <= pv_q;
			else if (cmd.mul) res <= cv_q;
			else res <= neg_q ? pv_q - $signed(quo_q) : pv_q + $signed(quo_q);
		end
	end

	`ASSERT_NEXT(a_div_count, clk, arst_n, cmd.div_go, cnt_q == 7'(P))
	`ASSERT_IMPL(a_no_mul_div, clk, arst_n, !(cmd.div_go && cmd.div_step))
	`ASSERT_IMPL(a_no_wr_rd, clk, arst_n, !(cmd.wr && cmd.rd))
endmodule
`default_nettype wire

// ===== src/til_ctrl.sv =====
// ----------------------------------------------------------------------------
// til_ctrl: lookup sequencer
// Scans the table one entry at a time (read in S_RD, compare in S_CHK) and steers the divider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module til_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          mode,
	input  wire logic [1:0]                    imode,
	input  wire logic                          inv,
	input  wire logic [til_pkg::CntBits-1:0]   count,
	input  wire til_pkg::sts_t                 sts,
	output til_pkg::cmd_t                      cmd,
	output logic                               busy,
	output logic                               sel_prev,
	output logic                               done,
	output logic                               empty
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001, S_RD = 7'b0000010, S_CHK = 7'b0000100,
		S_MUL  = 7'b0001000, S_DIV = 7'b0010000, S_FIN = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [til_pkg::CntBits-1:0] i_q, n_q;
	logic [1:0] im_q;
	logic       direct_q, sel_q;

	assign busy = state_q != S_IDLE;
	assign sel_prev = sel_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		cmd.rd_idx = i_q[til_pkg::IdxBits-1:0];
		case (state_q)
			S_IDLE: begin
				if (start && mode && count != '0) state_d = S_RD;
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (sts.ge || i_q == n_q - 7'd1) begin
					cmd.cap_cur = 1'b1;
					state_d = S_MUL;
				end else begin
					cmd.cap_prev = 1'b1;
					state_d = S_RD;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				if (direct_q || im_q == til_pkg::ImodeFwd || im_q == til_pkg::ImodeBwd) begin
					cmd.fin = 1'b1;
					state_d = S_OUT;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_go = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					cmd.div_step = 1'b0;
					cmd.fin = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q <= '0; n_q <= '0; im_q <= '0;
			direct_q <= 1'b0; sel_q <= 1'b0;
			done <= 1'b0; empty <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= 1'b0;
			if (state_q == S_IDLE && start && mode) begin
				n_q   <= (count > 7'(til_pkg::MaxPoints)) ? 7'(til_pkg::MaxPoints) : count;
				im_q  <= inv ? til_pkg::ImodeInterp : imode;
				i_q   <= '0;
				sel_q <= 1'b0;
				direct_q <= 1'b0;
				if (count == '0) begin
					empty <= 1'b1;
					done  <= 1'b1;
				end else begin
					empty <= 1'b0;
				end
			end
			if (state_q == S_CHK) begin
				if (sts.ge || i_q == n_q - 7'd1) begin
					// First entry, exact hit, or ran off the end: take this value.
					direct_q <= (i_q == '0) || sts.eq || !sts.ge;
					sel_q <= sts.ge && !sts.eq && (i_q != '0) &&
					         (im_q == til_pkg::ImodeBwd);
				end else begin
					i_q <= i_q + 7'd1;
				end
			end
			if (state_q == S_MUL && state_d == S_OUT && !direct_q && im_q == til_pkg::ImodeFwd)
				direct_q <= 1'b1;
			if (state_q == S_OUT) done <= 1'b1;
		end
	end

	`ASSERT_IMPL(a_onehot, clk, arst_n, $onehot(state_q))
	`ASSERT_NEXT(a_out_done, clk, arst_n, state_q == S_OUT, done && state_q == S_IDLE)
	`ASSERT_IMPL(a_idx_range, clk, arst_n, !busy || state_q == S_OUT || i_q < n_q)
endmodule
`default_nettype wire

// ===== src/table_interpolation_lookup.sv =====
// A load writes its point when accepted and leaves busy low. A query reads and
// compares entries in S_RD/S_CHK, then S_MUL and, if interpolating, S_DIV and S_FIN.
// Busy is high from acceptance until the strobe cycle; an empty table strobes in the next cycle.
// Throughput: one item at a time; the next may be accepted in the strobe cycle.
// Reset clears the configured point count and the sequencer; the table is undefined until loaded.
// The receiver cannot stall: result_valid lasts exactly one cycle.
`default_nettype none
module table_interpolation_lookup (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                mode,
	input  wire logic [til_pkg::IdxBits-1:0]         point_index,
	input  wire logic signed [til_pkg::VBits-1:0]    point_x,
	input  wire logic signed [til_pkg::VBits-1:0]    point_y,
	input  wire logic signed [til_pkg::VBits-1:0]    query_value,
	input  wire logic [1:0]                          interp_mode,
	input  wire logic                                invert,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [til_pkg::CntBits-1:0]         cfg_data,
	output logic                                     result_valid,
	output logic signed [til_pkg::VBits-1:0]         result_value,
	output logic                                     status
);
	til_pkg::cmd_t cmd, ccmd;
	til_pkg::sts_t sts;
	logic [til_pkg::CntBits-1:0] count_q;
	logic signed [til_pkg::VBits-1:0] q_q, res;
	logic inv_q, sel_prev, done, empty, cbusy;

	assign cfg_ready = 1'b1;
	assign busy = cbusy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			inv_q <= 1'b0;
		end else begin
			if (cfg_valid) count_q <= cfg_data;
			if (start && !cbusy) inv_q <= invert;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !cbusy) q_q <= query_value;
	end

	always_comb begin
		cmd = ccmd;
		cmd.wr = start && !cbusy && !mode;
	end

	til_ctrl u_ctrl (
		.clk, .arst_n, .start, .mode, .imode(interp_mode), .inv(invert),
		.count(count_q), .sts, .cmd(ccmd), .busy(cbusy), .sel_prev, .done, .empty
	);

	til_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .wr_idx(point_index), .wx(point_x), .wy(point_y),
		.q_in(q_q), .inv_in(inv_q), .sel_prev, .res
	);

	assign result_valid = done;
	assign status = empty;
	assign result_value = empty ? '0 : res;
endmodule
`default_nettype wire
